### hdl/http_request_head_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// HTTP request head parser assertion macros
// Shared concurrent check forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEAD_PARSER_UNIT_DEFINES_SVH
`define HTTP_REQUEST_HEAD_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define HRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hrp: check failed");

// next-cycle implication
`define HRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hrp: check failed");

`endif

### hdl/hrp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request head parser package
// Status and role codes, character constants and shared types.
// ----------------------------------------------------------------------------
package hrp_pkg;

    localparam logic [1:0] ST_PENDING = 2'd0;
    localparam logic [1:0] ST_GOOD    = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    localparam logic [2:0] ROLE_SYNTAX     = 3'd0;
    localparam logic [2:0] ROLE_METHOD     = 3'd1;
    localparam logic [2:0] ROLE_URI        = 3'd2;
    localparam logic [2:0] ROLE_NAME_FIRST = 3'd3;
    localparam logic [2:0] ROLE_NAME       = 3'd4;
    localparam logic [2:0] ROLE_VALUE      = 3'd5;

    localparam logic [7:0] C_DIGIT_BASE = 8'h30;
    localparam logic [7:0] C_DIGIT_LAST = 8'h39;
    localparam logic [7:0] C_CTRL_MAX   = 8'd31;
    localparam logic [7:0] C_DEL        = 8'd127;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;

    typedef struct packed {
        logic is_ctrl;
        logic is_token;
        logic is_digit;
        logic is_blank;
    } t_char_class;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] byte_role;
        logic [7:0] major_version;
        logic [7:0] minor_version;
    } t_result;

    // acc*10 + digit, saturated at 255
    function automatic logic [7:0] f_dec_acc(logic [7:0] acc, logic [3:0] digit);
        logic [11:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'h00, digit};
        return (v > 12'd255) ? 8'hFF : v[7:0];
    endfunction

endpackage

### hdl/hrp_if.sv
// ----------------------------------------------------------------------------
// HTTP request head parser channels
// Valid/ready channels for request bytes and parse results.
// ----------------------------------------------------------------------------
interface hrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       restart;

    modport source (output valid, output byte_in, output restart, input ready);
    modport sink   (input valid, input byte_in, input restart, output ready);
endinterface

interface hrp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] byte_role;
    logic [7:0] echo_byte;
    logic [7:0] major_version;
    logic [7:0] minor_version;

    modport source (output valid, output status, output byte_role, output echo_byte,
                    output major_version, output minor_version, input ready);
    modport sink   (input valid, input status, input byte_role, input echo_byte,
                    input major_version, input minor_version, output ready);
endinterface

### hdl/hrp_classify.sv
// ----------------------------------------------------------------------------
// HTTP request head parser character classifier
// Control, token, digit and blank tests on one byte.
// ----------------------------------------------------------------------------
module hrp_classify
    import hrp_pkg::*;
(
    input  logic [7:0]  i_byte,
    output t_char_class o_cls
);

    logic w_sep;

    always_comb begin
        case (i_byte)
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40,
            8'h2C, 8'h3B, CH_COLON, 8'h5C, 8'h22,
            CH_SLASH, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
            8'h7B, 8'h7D, CH_SP, CH_TAB: begin
                w_sep = 1'b1;
            end
            default: begin
                w_sep = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_cls.is_ctrl  = (i_byte <= C_CTRL_MAX) || (i_byte == C_DEL);
        o_cls.is_token = (i_byte <= C_DEL) && !o_cls.is_ctrl && !w_sep;
        o_cls.is_digit = (i_byte >= C_DIGIT_BASE) && (i_byte <= C_DIGIT_LAST);
        o_cls.is_blank = (i_byte == CH_SP) || (i_byte == CH_TAB);
    end

endmodule

### hdl/hrp_fsm.sv
// ----------------------------------------------------------------------------
// HTTP request head parser state machine
// Parse phase, header flag and version accumulators; per-beat result.
// ----------------------------------------------------------------------------
`include "http_request_head_parser_unit_defines.svh"

module hrp_fsm
    import hrp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_restart,
    input  logic [7:0]  i_byte,
    input  t_char_class i_cls,
    input  logic        i_skip_uri,
    output t_result     o_res
);

    typedef enum logic [4:0] {
        P_START   = 5'd0,
        P_METHOD  = 5'd1,
        P_URI     = 5'd2,
        P_H       = 5'd3,
        P_T1      = 5'd4,
        P_T2      = 5'd5,
        P_P       = 5'd6,
        P_SLASH   = 5'd7,
        P_MAJOR   = 5'd8,
        P_MINOR   = 5'd9,
        P_FIRSTLF = 5'd10,
        P_LINEBEG = 5'd11,
        P_NAME    = 5'd12,
        P_VALUE   = 5'd13,
        P_LWS     = 5'd14,
        P_SPACE   = 5'd15,
        P_LF      = 5'd16,
        P_ENDLF   = 5'd17,
        P_DONE    = 5'd18
    } t_phase;

    t_phase     r_phase, n_phase, w_phase;
    logic       r_seen_header, n_seen_header, w_seen_header;
    logic [7:0] r_major, n_major, w_major;
    logic [7:0] r_minor, n_minor, w_minor;
    logic [1:0] w_status;
    logic [2:0] w_role;

    always_comb begin
        w_phase       = i_restart ? P_START : r_phase;
        w_seen_header = i_restart ? 1'b0 : r_seen_header;
        w_major       = i_restart ? 8'h00 : r_major;
        w_minor       = i_restart ? 8'h00 : r_minor;

        n_phase       = w_phase;
        n_seen_header = w_seen_header;
        n_major       = w_major;
        n_minor       = w_minor;
        w_status      = ST_PENDING;
        w_role        = ROLE_SYNTAX;

        case (w_phase)
            P_START: begin
                if (!i_cls.is_token) begin
                    w_status = ST_BAD;
                end else begin
                    w_role  = ROLE_METHOD;
                    n_phase = P_METHOD;
                end
            end
            P_METHOD: begin
                if (i_byte == CH_SP) begin
                    n_phase = i_skip_uri ? P_H : P_URI;
                end else if (!i_cls.is_token) begin
                    w_status = ST_BAD;
                end else begin
                    w_role = ROLE_METHOD;
                end
            end
            P_URI: begin
                if (i_byte == CH_SP) begin
                    n_phase = P_H;
                end else if (i_cls.is_ctrl) begin
                    w_status = ST_BAD;
                end else begin
                    w_role = ROLE_URI;
                end
            end
            P_H: begin
                if (i_byte == CH_H) n_phase = P_T1;
                else w_status = ST_BAD;
            end
            P_T1: begin
                if (i_byte == CH_T) n_phase = P_T2;
                else w_status = ST_BAD;
            end
            P_T2: begin
                if (i_byte == CH_T) n_phase = P_P;
                else w_status = ST_BAD;
            end
            P_P: begin
                if (i_byte == CH_P) n_phase = P_SLASH;
                else w_status = ST_BAD;
            end
            P_SLASH: begin
                if (i_byte == CH_SLASH) n_phase = P_MAJOR;
                else w_status = ST_BAD;
            end
            P_MAJOR: begin
                if (i_byte == CH_DOT) begin
                    n_phase = P_MINOR;
                end else if (i_cls.is_digit) begin
                    n_major = f_dec_acc(w_major, i_byte[3:0]);
                end else begin
                    w_status = ST_BAD;
                end
            end
            P_MINOR: begin
                if (i_byte == CH_CR) begin
                    n_phase = P_FIRSTLF;
                end else if (i_cls.is_digit) begin
                    n_minor = f_dec_acc(w_minor, i_byte[3:0]);
                end else begin
                    w_status = ST_BAD;
                end
            end
            P_FIRSTLF: begin
                if (i_byte == CH_LF) n_phase = P_LINEBEG;
                else w_status = ST_BAD;
            end
            P_LINEBEG: begin
                if (i_byte == CH_CR) begin
                    n_phase = P_ENDLF;
                end else if (w_seen_header && i_cls.is_blank) begin
                    n_phase = P_LWS;
                end else if (!i_cls.is_token) begin
                    w_status = ST_BAD;
                end else begin
                    n_seen_header = 1'b1;
                    w_role        = ROLE_NAME_FIRST;
                    n_phase       = P_NAME;
                end
            end
            P_LWS: begin
                if (i_byte == CH_CR) begin
                    n_phase = P_LF;
                end else if (i_cls.is_blank) begin
                    n_phase = P_LWS;
                end else if (i_cls.is_ctrl) begin
                    w_status = ST_BAD;
                end else begin
                    w_role  = ROLE_VALUE;
                    n_phase = P_VALUE;
                end
            end
            P_NAME: begin
                if (i_byte == CH_COLON) begin
                    n_phase = P_SPACE;
                end else if (!i_cls.is_token) begin
                    w_status = ST_BAD;
                end else begin
                    w_role = ROLE_NAME;
                end
            end
            P_SPACE: begin
                if (i_byte == CH_SP) n_phase = P_VALUE;
                else w_status = ST_BAD;
            end
            P_VALUE: begin
                if (i_byte == CH_CR) begin
                    n_phase = P_LF;
                end else if (i_cls.is_ctrl) begin
                    w_status = ST_BAD;
                end else begin
                    w_role = ROLE_VALUE;
                end
            end
            P_LF: begin
                if (i_byte == CH_LF) n_phase = P_LINEBEG;
                else w_status = ST_BAD;
            end
            P_ENDLF: begin
                if (i_byte == CH_LF) begin
                    w_status = ST_GOOD;
                    n_phase  = P_DONE;
                end else begin
                    w_status = ST_BAD;
                end
            end
            default: begin
                w_status = ST_BAD;
            end
        endcase

        // bad beat: keep state as it was
        if (w_status == ST_BAD) begin
            w_role        = ROLE_SYNTAX;
            n_phase       = w_phase;
            n_seen_header = w_seen_header;
            n_major       = w_major;
            n_minor       = w_minor;
        end

        o_res.status        = w_status;
        o_res.byte_role     = w_role;
        o_res.major_version = n_major;
        o_res.minor_version = n_minor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= P_START;
            r_seen_header <= 1'b0;
            r_major       <= 8'h00;
            r_minor       <= 8'h00;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_seen_header <= n_seen_header;
            r_major       <= n_major;
            r_minor       <= n_minor;
        end
    end

    `HRP_ASSERT_NXT(a_good_enters_done, i_clk, i_rst_n, i_accept && (o_res.status == ST_GOOD), r_phase == P_DONE)
    `HRP_ASSERT_NXT(a_bad_holds_state, i_clk, i_rst_n, i_accept && !i_restart && (o_res.status == ST_BAD), $stable(r_phase) && $stable(r_major) && $stable(r_minor))
    `HRP_ASSERT_IMP(a_name_needs_flag, i_clk, i_rst_n, r_phase == P_NAME, r_seen_header)

endmodule

### hdl/http_request_head_parser_unit.sv
// ----------------------------------------------------------------------------
// HTTP request head parser unit
// Byte-at-a-time parse of an HTTP/1.x request line and header block.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request byte per beat plus a restart flag that clears
//   the parse state before that byte. o_res returns one beat per input beat:
//   status (pending, head complete, bad byte), the byte's role, the byte
//   itself and the running major/minor version numbers.
//   i_cfg_we/i_cfg_wdata write skip_uri; write it only while the unit is idle.
//   The result beat is registered and appears in the cycle after its input
//   beat is accepted. Throughput is one byte per cycle while the receiver
//   takes each result: the phase update and the result are one short decode
//   between the parse state registers and the result register.
//   Reset (synchronous, active low) returns the parser to the start of a
//   method, clears the versions and skip_uri, and empties the result register.
//   When the receiver stalls, the result beat holds and i_req.ready drops
//   until it is taken; a beat is accepted in the same cycle the held result
//   leaves.
// ----------------------------------------------------------------------------
`include "http_request_head_parser_unit_defines.svh"

module http_request_head_parser_unit
    import hrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    hrp_in_if.sink     i_req,
    hrp_out_if.source  o_res
);

    t_char_class w_cls;
    t_result     w_res;
    logic        w_accept;
    logic        r_skip_uri;
    logic        r_out_valid;
    t_result     r_res;
    logic [7:0]  r_echo;

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    hrp_classify u_classify (
        .i_byte (i_req.byte_in),
        .o_cls  (w_cls)
    );

    hrp_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_restart  (i_req.restart),
        .i_byte     (i_req.byte_in),
        .i_cls      (w_cls),
        .i_skip_uri (r_skip_uri),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_uri <= 1'b0;
        end else if (i_cfg_we) begin
            r_skip_uri <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res  <= w_res;
            r_echo <= i_req.byte_in;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_res.status;
    assign o_res.byte_role     = r_res.byte_role;
    assign o_res.echo_byte     = r_echo;
    assign o_res.major_version = r_res.major_version;
    assign o_res.minor_version = r_res.minor_version;

    `HRP_ASSERT_NXT(a_accept_fills_out, i_clk, i_rst_n, w_accept, r_out_valid)
    `HRP_ASSERT_IMP(a_bad_has_no_role, i_clk, i_rst_n, r_out_valid && (r_res.status == ST_BAD), r_res.byte_role == ROLE_SYNTAX)
    `HRP_ASSERT_NXT(a_stall_holds_beat, i_clk, i_rst_n, r_out_valid && !o_res.ready, r_out_valid && $stable(r_res) && $stable(r_echo))

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// HTTP request head parser testbench
// Drives request bytes on the input channel and keeps its own copy of the
// parse state to predict each result beat. Results are checked field by field
// in arrival order. The run starts with a short hand-built request. It then
// sends random well-formed requests mixed with stray bytes, early aborts and
// trailing bytes, across both skip_uri settings and several idle and stall
// mixes, including one long receiver hold.
// ----------------------------------------------------------------------------
module tb;
    import hrp_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 200;
    localparam int MAX_PRINTS  = 100;

    typedef enum logic [4:0] {
        P_START, P_METHOD, P_URI, P_H, P_T1, P_T2, P_P, P_SLASH, P_MAJOR, P_MINOR,
        P_FIRSTLF, P_LINEBEG, P_NAME, P_VALUE, P_LWS, P_SPACE, P_LF, P_ENDLF, P_DONE
    } head_phase_e;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] role;
        logic [7:0] echo_byte;
        logic [7:0] major;
        logic [7:0] minor;
    } parse_beat_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    hrp_in_if  req_if ();
    hrp_out_if res_if ();

    http_request_head_parser_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    head_phase_e phase     = P_START;
    logic        seen_hdr  = 1'b0;
    logic [7:0]  major_acc = 8'd0;
    logic [7:0]  minor_acc = 8'd0;
    logic        skip_uri  = 1'b0;

    parse_beat_t beats_due[$];
    logic [7:0]  req_bytes[$];

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_reqs      = 0;
    int          hold_taken     = 0;
    int          stall_left     = 0;
    int          errors         = 0;
    int          bytes_sent     = 0;
    int unsigned quiet_cycles   = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic is_ctl(input logic [7:0] b);
        return (b <= C_CTRL_MAX) || (b == C_DEL);
    endfunction

    function automatic logic is_sep(input logic [7:0] b);
        case (b)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
            "/", "[", "]", "?", "=", "{", "}", CH_SP, CH_TAB: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_tok(input logic [7:0] b);
        return (b <= C_DEL) && !is_ctl(b) && !is_sep(b);
    endfunction

    function automatic logic is_dig(input logic [7:0] b);
        return (b >= C_DIGIT_BASE) && (b <= C_DIGIT_LAST);
    endfunction

    function automatic logic [7:0] acc10(input logic [7:0] acc, input logic [7:0] b);
        int v;
        v = int'(acc) * 10 + int'(b - C_DIGIT_BASE);
        return (v > 255) ? 8'hFF : v[7:0];
    endfunction

    // advance the parse state by one byte and queue the beat it yields
    task automatic predict_byte(input logic [7:0] b, input logic rs);
        parse_beat_t e;
        logic        bad;
        logic        good;
        logic [2:0]  role;
        bad  = 1'b0;
        good = 1'b0;
        role = ROLE_SYNTAX;
        if (rs) begin
            phase     = P_START;
            seen_hdr  = 1'b0;
            major_acc = 8'd0;
            minor_acc = 8'd0;
        end
        case (phase)
            P_START: begin
                if (!is_tok(b)) bad = 1'b1;
                else begin
                    role  = ROLE_METHOD;
                    phase = P_METHOD;
                end
            end
            P_METHOD: begin
                if (b == CH_SP) phase = skip_uri ? P_H : P_URI;
                else if (!is_tok(b)) bad = 1'b1;
                else role = ROLE_METHOD;
            end
            P_URI: begin
                if (b == CH_SP) phase = P_H;
                else if (is_ctl(b)) bad = 1'b1;
                else role = ROLE_URI;
            end
            P_H:     if (b == CH_H) phase = P_T1; else bad = 1'b1;
            P_T1:    if (b == CH_T) phase = P_T2; else bad = 1'b1;
            P_T2:    if (b == CH_T) phase = P_P; else bad = 1'b1;
            P_P:     if (b == CH_P) phase = P_SLASH; else bad = 1'b1;
            P_SLASH: if (b == CH_SLASH) phase = P_MAJOR; else bad = 1'b1;
            P_MAJOR: begin
                if (b == CH_DOT) phase = P_MINOR;
                else if (is_dig(b)) major_acc = acc10(major_acc, b);
                else bad = 1'b1;
            end
            P_MINOR: begin
                if (b == CH_CR) phase = P_FIRSTLF;
                else if (is_dig(b)) minor_acc = acc10(minor_acc, b);
                else bad = 1'b1;
            end
            P_FIRSTLF: if (b == CH_LF) phase = P_LINEBEG; else bad = 1'b1;
            P_LINEBEG: begin
                if (b == CH_CR) phase = P_ENDLF;
                else if (seen_hdr && (b == CH_SP || b == CH_TAB)) phase = P_LWS;
                else if (!is_tok(b)) bad = 1'b1;
                else begin
                    seen_hdr = 1'b1;
                    role     = ROLE_NAME_FIRST;
                    phase    = P_NAME;
                end
            end
            P_LWS: begin
                if (b == CH_CR) phase = P_LF;
                else if (b == CH_SP || b == CH_TAB) role = ROLE_SYNTAX;
                else if (is_ctl(b)) bad = 1'b1;
                else begin
                    role  = ROLE_VALUE;
                    phase = P_VALUE;
                end
            end
            P_NAME: begin
                if (b == CH_COLON) phase = P_SPACE;
                else if (!is_tok(b)) bad = 1'b1;
                else role = ROLE_NAME;
            end
            P_SPACE: if (b == CH_SP) phase = P_VALUE; else bad = 1'b1;
            P_VALUE: begin
                if (b == CH_CR) phase = P_LF;
                else if (is_ctl(b)) bad = 1'b1;
                else role = ROLE_VALUE;
            end
            P_LF: if (b == CH_LF) phase = P_LINEBEG; else bad = 1'b1;
            P_ENDLF: begin
                if (b == CH_LF) begin
                    good  = 1'b1;
                    phase = P_DONE;
                end else bad = 1'b1;
            end
            default: bad = 1'b1;
        endcase
        e.status    = bad ? ST_BAD : (good ? ST_GOOD : ST_PENDING);
        e.role      = bad ? ROLE_SYNTAX : role;
        e.echo_byte = b;
        e.major     = major_acc;
        e.minor     = minor_acc;
        beats_due.insert(beats_due.size(), e);
    endtask

    task automatic report(input string what, input int got, input int want);
        if (errors < MAX_PRINTS)
            $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin : rx_side
        parse_beat_t want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (beats_due.size() == 0) begin
                report("beat with nothing due, byte", int'(res_if.echo_byte), 0);
            end else begin
                want = beats_due.pop_front();
                if (res_if.status != want.status)
                    report("status", int'(res_if.status), int'(want.status));
                if (res_if.byte_role != want.role)
                    report("byte_role", int'(res_if.byte_role), int'(want.role));
                if (res_if.echo_byte != want.echo_byte)
                    report("echo_byte", int'(res_if.echo_byte), int'(want.echo_byte));
                if (res_if.major_version != want.major)
                    report("major_version", int'(res_if.major_version), int'(want.major));
                if (res_if.minor_version != want.minor)
                    report("minor_version", int'(res_if.minor_version), int'(want.minor));
            end
        end
    end

    always @(posedge i_clk) begin : rx_ready
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left--;
        end else if (hold_reqs != hold_taken) begin
            stall_left    = LONG_HOLD - 1;
            hold_taken    = hold_reqs;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic rs);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.byte_in <= b;
        req_if.restart <= rs;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predict_byte(b, rs);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) send_byte(s[i], 1'b0);
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        skip_uri  = v;
    endtask

    function automatic logic [7:0] tok_char();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 126)); while (!is_tok(c));
        return c;
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        if ($urandom_range(19) == 0) return 8'($urandom_range(255));
        do c = 8'($urandom_range(32, 255)); while (c == C_DEL);
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        return $urandom_range(1) ? CH_SP : CH_TAB;
    endfunction

    task automatic put_byte(input logic [7:0] b);
        req_bytes.insert(req_bytes.size(), b);
    endtask

    // build one request head with random content, then send it with stray bytes
    task automatic send_request();
        string hver;
        int    n_send;
        logic  rs_first;
        hver = "HTTP/";
        req_bytes.delete();
        repeat ($urandom_range(1, 6)) put_byte(tok_char());
        put_byte(CH_SP);
        if (!skip_uri || $urandom_range(9) == 0) begin
            repeat ($urandom_range(0, 8)) put_byte(text_char());
            put_byte(CH_SP);
        end
        foreach (hver[i]) put_byte(hver[i]);
        repeat ($urandom_range(0, 4)) put_byte(C_DIGIT_BASE + 8'($urandom_range(9)));
        put_byte(CH_DOT);
        repeat ($urandom_range(0, 4)) put_byte(C_DIGIT_BASE + 8'($urandom_range(9)));
        put_byte(CH_CR);
        put_byte(CH_LF);
        if ($urandom_range(9) == 0) put_byte(blank_char());
        repeat ($urandom_range(0, 4)) begin
            repeat ($urandom_range(1, 6)) put_byte(tok_char());
            put_byte(CH_COLON);
            put_byte(CH_SP);
            repeat ($urandom_range(0, 8)) put_byte(text_char());
            put_byte(CH_CR);
            put_byte(CH_LF);
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 2)) put_byte(blank_char());
                repeat ($urandom_range(0, 6)) put_byte(text_char());
                put_byte(CH_CR);
                put_byte(CH_LF);
            end
        end
        put_byte(CH_CR);
        put_byte(CH_LF);
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(255)));
        n_send   = ($urandom_range(19) == 0) ? int'($urandom_range(1, req_bytes.size()))
                                             : req_bytes.size();
        rs_first = ($urandom_range(19) != 0);
        for (int i = 0; i < n_send; i++) begin
            if ($urandom_range(49) == 0)
                send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
            send_byte(req_bytes[i], rs_first && (i == 0));
        end
    endtask

    task automatic run_traffic(input int n_bytes, input int idle_pct, input int stall_pct);
        int start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start          = bytes_sent;
        while (bytes_sent - start < n_bytes) send_request();
        wait_idle();
    endtask

    task automatic test_directed();
        cfg_write(1'b0);
        send_byte(8'h00, 1'b1);
        send_text("A ");
        send_byte(8'hFF, 1'b0);
        send_text(" HTTP/.999");
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_text("X: ");
        send_byte(8'hFF, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_text(" v");
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(C_DEL, 1'b0);
        wait_idle();
    endtask

    task automatic test_skip_uri();
        cfg_write(1'b1);
        run_traffic(250, 0, 0);
    endtask

    task automatic test_sender_idle();
        cfg_write(1'b0);
        run_traffic(300, 75, 0);
    endtask

    task automatic test_receiver_stall();
        cfg_write(1'b1);
        run_traffic(300, 0, 75);
    endtask

    task automatic test_long_hold();
        cfg_write(1'b0);
        hold_reqs++;
        run_traffic(120, 0, 0);
    endtask

    task automatic test_mixed_idle();
        cfg_write(1'b1);
        run_traffic(450, 36, 36);
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.byte_in <= 8'h00;
        req_if.restart <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_skip_uri();
        test_sender_idle();
        test_receiver_stall();
        test_long_hold();
        test_mixed_idle();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
